FILE: src/ptoq_pkg.sv
// ptoq_pkg: shared types and constants for the pulse train obstruction qualifier.
// No dependencies; imported by every module of the block.
package ptoq_pkg;

    localparam int TICK_W  = 32;
    localparam int CNT_W   = 5;
    localparam int CFG_W   = 24;
    localparam int CIDX_W  = 8;

    localparam logic [CNT_W-1:0] PULSE_SAT = 5'd31;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_WINDOW_TICKS  = 8'd0;
    localparam logic [CIDX_W-1:0] REG_HIGH_TIMEOUT  = 8'd1;
    localparam logic [CIDX_W-1:0] REG_MIN_PULSES    = 8'd2;
    localparam logic [CIDX_W-1:0] REG_MAX_PULSES    = 8'd3;

    // configuration reset values
    localparam logic [CFG_W-1:0] WINDOW_TICKS_RST = 24'd50000;
    localparam logic [CFG_W-1:0] HIGH_TIMEOUT_RST = 24'd70000;
    localparam logic [CNT_W-1:0] MIN_PULSES_RST   = 5'd3;
    localparam logic [CNT_W-1:0] MAX_PULSES_RST   = 5'd8;

    typedef enum logic [1:0] {
        ST_CLEAR      = 2'd0,
        ST_OBSTRUCTED = 2'd1,
        ST_UNKNOWN    = 2'd2
    } sensor_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] window_ticks;
        logic [CFG_W-1:0] high_timeout_ticks;
        logic [CNT_W-1:0] min_pulses;
        logic [CNT_W-1:0] max_pulses;
    } cfg_t;

    typedef struct packed {
        sensor_state_t state;
        logic          changed;
    } result_t;

endpackage

FILE: src/ptoq_cfg.sv
// ptoq_cfg: configuration register file of the obstruction qualifier.
// Depends on ptoq_pkg.
module ptoq_cfg
    import ptoq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [CIDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]  wr_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_WINDOW_TICKS: cfg_next.window_ticks       = wr_data;
                REG_HIGH_TIMEOUT: cfg_next.high_timeout_ticks = wr_data;
                REG_MIN_PULSES:   cfg_next.min_pulses         = wr_data[CNT_W-1:0];
                REG_MAX_PULSES:   cfg_next.max_pulses         = wr_data[CNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ticks       <= WINDOW_TICKS_RST;
            cfg_reg.high_timeout_ticks <= HIGH_TIMEOUT_RST;
            cfg_reg.min_pulses         <= MIN_PULSES_RST;
            cfg_reg.max_pulses         <= MAX_PULSES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/ptoq_eval.sv
// ptoq_eval: edge detection, pulse counting and window judgement, one sample per step.
// Depends on ptoq_pkg.
module ptoq_eval
    import ptoq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    level,
    input  cfg_t    cfg,
    output result_t result
);

    logic [TICK_W-1:0] tick_reg,       tick_next;
    logic [TICK_W-1:0] win_start_reg,  win_start_next;
    logic [TICK_W-1:0] last_high_reg,  last_high_next;
    logic [CNT_W-1:0]  pulse_cnt_reg,  pulse_cnt_next;
    logic              armed_reg,      armed_next;
    logic              prev_level_reg, prev_level_next;
    sensor_state_t     state_reg,      state_next;

    logic              rise;
    logic              fall;
    logic [CNT_W-1:0]  cnt_edge;
    logic              armed_edge;
    logic [TICK_W-1:0] elapsed;
    logic [TICK_W-1:0] high_age;
    logic              judge;
    logic              in_range;
    logic              obstructed;

    always_comb
    begin
        rise = level & ~prev_level_reg;
        fall = ~level & prev_level_reg;

        last_high_next = rise ? tick_reg : last_high_reg;
        cnt_edge       = (fall && (pulse_cnt_reg != PULSE_SAT)) ? pulse_cnt_reg + 5'd1
                                                                : pulse_cnt_reg;
        armed_edge     = armed_reg | fall;

        // differences wrap modulo 2^32
        elapsed  = tick_reg - win_start_reg;
        high_age = tick_reg - last_high_next;

        judge      = armed_edge && (elapsed > {{(TICK_W-CFG_W){1'b0}}, cfg.window_ticks});
        in_range   = (cnt_edge >= cfg.min_pulses) && (cnt_edge <= cfg.max_pulses);
        obstructed = (cnt_edge == '0) && level &&
                     (high_age > {{(TICK_W-CFG_W){1'b0}}, cfg.high_timeout_ticks});

        state_next     = state_reg;
        win_start_next = win_start_reg;
        pulse_cnt_next = cnt_edge;
        if (judge)
        begin
            if (in_range)
                state_next = ST_CLEAR;
            else if (obstructed)
                state_next = ST_OBSTRUCTED;
            win_start_next = tick_reg;
            pulse_cnt_next = '0;
        end

        armed_next      = armed_edge;
        prev_level_next = level;
        tick_next       = tick_reg + 32'd1;
    end

    always_comb
    begin
        result.state   = state_next;
        result.changed = (state_next != state_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            win_start_reg  <= '0;
            last_high_reg  <= '0;
            pulse_cnt_reg  <= '0;
            armed_reg      <= 1'b0;
            prev_level_reg <= 1'b0;
            state_reg      <= ST_UNKNOWN;
        end
        else if (step)
        begin
            tick_reg       <= tick_next;
            win_start_reg  <= win_start_next;
            last_high_reg  <= last_high_next;
            pulse_cnt_reg  <= pulse_cnt_next;
            armed_reg      <= armed_next;
            prev_level_reg <= prev_level_next;
            state_reg      <= state_next;
        end
    end

endmodule

FILE: src/pulse_train_obstruction_qualifier.sv
// Pulse train obstruction qualifier. One line sample is taken per transfer and
// yields exactly one result (sensor state and changed flag). Samples pass an input
// register, combinational evaluation logic and a result register, so a new sample is
// taken every cycle unless the output stalls; the result register plus the input
// register let one more sample in while a result is stalled. Configuration is
// written through the cfg port (index 0 window, 1 high timeout, 2 min, 3 max pulses)
// while the block is idle (user's rule, unenforced); other index writes are ignored.
// Depends on ptoq_pkg, ptoq_cfg, ptoq_eval.
module pulse_train_obstruction_qualifier
    import ptoq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              line_level,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        sensor_state,
    output logic              state_changed,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t eval_result;

    logic    in_valid_reg;
    logic    in_valid_next;
    logic    level_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    logic    advance;
    logic    in_take;

    assign cfg_ready = 1'b1;

    ptoq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // input stage moves into the result register when that one is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    ptoq_eval u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .level  (level_reg),
        .cfg    (cfg),
        .result (eval_result)
    );

    always_comb
    begin
        in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : ((out_valid_reg && !out_stall) ? 1'b0
                                                                         : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            level_reg <= line_level;
        if (advance)
            out_reg <= eval_result;
    end

    assign out_valid     = out_valid_reg;
    assign sensor_state  = out_reg.state;
    assign state_changed = out_reg.changed;

endmodule

FILE: tb/sv/ptoq_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the pulse train obstruction qualifier: a sample-accurate copy of
// the qualifier state that predicts one sensor state per sample. Needs ptoq_pkg.
package ptoq_scoreboard_pkg;

    import ptoq_pkg::*;

    class ptoq_scoreboard;

        cfg_t              regs;
        logic [TICK_W-1:0] tick_now;
        logic [TICK_W-1:0] window_start;
        logic [TICK_W-1:0] last_rise;
        logic [CNT_W-1:0]  pulses;
        logic              armed;
        logic              prev_level;
        sensor_state_t     cur_state;
        result_t           pending_states[$];
        int                errors;

        function new();
            regs.window_ticks       = WINDOW_TICKS_RST;
            regs.high_timeout_ticks = HIGH_TIMEOUT_RST;
            regs.min_pulses         = MIN_PULSES_RST;
            regs.max_pulses         = MAX_PULSES_RST;
            tick_now     = '0;
            window_start = '0;
            last_rise    = '0;
            pulses       = '0;
            armed        = 1'b0;
            prev_level   = 1'b0;
            cur_state    = ST_UNKNOWN;
            errors       = 0;
        endfunction

        function int pending();
            return pending_states.size();
        endfunction

        // register write as seen at the cfg transfer; unused indexes are dropped
        function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_WINDOW_TICKS: regs.window_ticks       = data;
                REG_HIGH_TIMEOUT: regs.high_timeout_ticks = data;
                REG_MIN_PULSES:   regs.min_pulses         = data[CNT_W-1:0];
                REG_MAX_PULSES:   regs.max_pulses         = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted sample: edges first, then window judgment, then the result
        function void advance_tick(logic lvl);
            sensor_state_t     prior;
            logic [TICK_W-1:0] elapsed;
            logic [TICK_W-1:0] high_age;
            result_t           res;
            prior = cur_state;
            if (lvl && !prev_level) begin
                last_rise = tick_now;
            end
            else if (!lvl && prev_level) begin
                armed = 1'b1;
                if (pulses != PULSE_SAT)
                    pulses = pulses + 1'b1;
            end
            prev_level = lvl;
            if (armed) begin
                elapsed  = tick_now - window_start;
                high_age = tick_now - last_rise;
                if (elapsed > TICK_W'(regs.window_ticks)) begin
                    // clear wins over obstructed when zero is inside the range
                    if (pulses >= regs.min_pulses && pulses <= regs.max_pulses)
                        cur_state = ST_CLEAR;
                    else if (pulses == '0 && lvl &&
                             high_age > TICK_W'(regs.high_timeout_ticks))
                        cur_state = ST_OBSTRUCTED;
                    window_start = tick_now;
                    pulses       = '0;
                end
            end
            res.state   = cur_state;
            res.changed = (cur_state != prior);
            pending_states.push_back(res);
            tick_now = tick_now + 1'b1;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_state(logic [1:0] st, logic chg);
            result_t exp;
            if (pending_states.size() == 0) begin
                report_mismatch($sformatf("unexpected result state=%0d changed=%0b", st, chg));
            end
            else begin
                exp = pending_states.pop_front();
                if (st !== exp.state)
                    report_mismatch($sformatf("sensor_state %0d, expected %0d", st, exp.state));
                if (chg !== exp.changed)
                    report_mismatch($sformatf("state_changed %0b, expected %0b",
                                              chg, exp.changed));
            end
        endtask

        task check_leftover();
            if (pending_states.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", pending_states.size()));
        endtask

    endclass

endpackage

FILE: tb/sv/tb_pulse_train_obstruction_qualifier.sv
`timescale 1ns / 100ps
// Top of the qualifier testbench: clock, reset, sample and cfg drivers, result sink.
// Needs ptoq_pkg, ptoq_scoreboard_pkg and the pulse_train_obstruction_qualifier RTL.
module tb_pulse_train_obstruction_qualifier;

    import ptoq_pkg::*;
    import ptoq_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_PAD      = 8;

    localparam logic [CIDX_W-1:0] REG_SPARE_LO = 8'd4;
    localparam logic [CIDX_W-1:0] REG_SPARE_HI = 8'hFF;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic              line_level    = 1'b0;
    logic              out_valid;
    logic              out_stall     = 1'b0;
    logic [1:0]        sensor_state;
    logic              state_changed;
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]  cfg_data      = '0;

    ptoq_scoreboard sb;
    bit             calm      = 1'b0;
    int             sink_hold = 0;
    int             idle_cycles = 0;

    always #10 clk = ~clk;

    pulse_train_obstruction_qualifier i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .line_level    (line_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sensor_state  (sensor_state),
        .state_changed (state_changed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // result sink: check on transfer, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_state(sensor_state, state_changed);
        if (sink_hold > 0)
        begin
            out_stall <= 1'b1;
            sink_hold = sink_hold - 1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 20);
    end

    // no transfer on any channel for too long means a hang
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic drive_sample(input logic lvl);
        while (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        line_level <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.advance_tick(lvl);
    endtask

    task automatic drive_run(input logic lvl, input int len);
        for (int k = 0; k < len; k++)
            drive_sample(lvl);
    endtask

    // stop offering and wait until every predicted state has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_t c);
        logic [CIDX_W-1:0] idx [5];
        logic [CFG_W-1:0]  val [5];
        drain();
        idx[0] = REG_WINDOW_TICKS;  val[0] = c.window_ticks;
        idx[1] = REG_HIGH_TIMEOUT;  val[1] = c.high_timeout_ticks;
        idx[2] = REG_MIN_PULSES;    val[2] = CFG_W'(c.min_pulses);
        idx[3] = REG_MAX_PULSES;    val[3] = CFG_W'(c.max_pulses);
        idx[4] = $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
        val[4] = CFG_W'($urandom);
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t make_cfg(int unsigned w, int unsigned t, int unsigned lo,
                                      int unsigned hi);
        cfg_t c;
        c.window_ticks       = CFG_W'(w);
        c.high_timeout_ticks = CFG_W'(t);
        c.min_pulses         = CNT_W'(lo);
        c.max_pulses         = CNT_W'(hi);
        return c;
    endfunction

    // fixed sequence, msb first
    task automatic run_pattern(input logic [31:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--)
            drive_sample(bits[i]);
    endtask

    // mostly pulse trains and steady stretches, some noise
    task automatic run_random(input int n);
        int done;
        int kind;
        int hi_len;
        int lo_len;
        int reps;
        int len;
        done = 0;
        while (done < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                hi_len = $urandom_range(1, 4);
                lo_len = $urandom_range(1, 4);
                reps   = $urandom_range(1, 12);
                for (int r = 0; r < reps && done < n; r++)
                begin
                    drive_run(1'b1, hi_len);
                    drive_run(1'b0, lo_len);
                    done += hi_len + lo_len;
                end
            end
            else if (kind < 70)
            begin
                len = $urandom_range(1, 120);
                drive_run(1'b1, len);
                done += len;
            end
            else if (kind < 85)
            begin
                len = $urandom_range(1, 40);
                drive_run(1'b0, len);
                done += len;
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++)
                    drive_sample(1'($urandom_range(0, 1)));
                done += len;
            end
        end
    endtask

    task automatic run_phase(input cfg_t c, input int n, input bit quiet, input bit pressure);
        write_cfg(c);
        calm = quiet;
        if (pressure)
        begin
            run_random(n / 3);
            // sink holds off while samples keep coming, so the input backs up
            sink_hold = HOLD_CYCLES;
            run_random(n / 3);
            drain();
            run_random(n / 3);
        end
        else
            run_random(n);
        calm = 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings; first sample high is a rising edge at tick zero
        run_pattern(32'b110010, 6);
        // short window: clear, then a steady high line turning obstructed
        write_cfg(make_cfg(2, 1, 1, 2));
        run_pattern(32'b0101011111100000010, 19);

        run_phase(make_cfg(20, 10, 3, 8), 250, 1'b0, 1'b0);
        run_phase(make_cfg(1, 1, 0, 0), 220, 1'b0, 1'b0);
        run_phase(make_cfg(64, 40, 0, 30), 300, 1'b1, 1'b1);
        run_phase(make_cfg(100, 24'hFFFFFF, 30, 30), 250, 1'b0, 1'b0);
        run_phase(make_cfg(24'hFFFFFF, 1, 2, 5), 150, 1'b0, 1'b0);
        run_phase(make_cfg(30, 5, 8, 3), 250, 1'b0, 1'b0);
        run_phase(make_cfg(8, 200, 1, 30), 200, 1'b0, 1'b0);

        drain();
        repeat (DRAIN_PAD) @(posedge clk);
        sb.check_leftover();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/ptoq_pkg.sv
src/ptoq_cfg.sv
src/ptoq_eval.sv
src/pulse_train_obstruction_qualifier.sv
tb/sv/ptoq_scoreboard_pkg.sv
tb/sv/tb_pulse_train_obstruction_qualifier.sv
